// ===== design/stt_pkg.sv =====
// Shared types, character classes and token codes for the script text tokenizer.
// No dependencies; imported by script_text_tokenizer.
package stt_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);
    localparam int TDATA_BITS  = 2 * OFFSET_BITS;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_COMMENT = 5'b00010,
        MODE_STRING  = 5'b00100,
        MODE_NUMBER  = 5'b01000,
        MODE_IDENT   = 5'b10000
    } t_mode;

    typedef enum logic [3:0] {
        KIND_COMMENT = 4'd0,
        KIND_EQUALS  = 4'd1,
        KIND_COLON   = 4'd2,
        KIND_OPEN    = 4'd3,
        KIND_CLOSE   = 4'd4,
        KIND_STRING  = 4'd5,
        KIND_NUMBER  = 4'd6,
        KIND_IDENT   = 4'd7,
        KIND_UNKNOWN = 4'd8,
        KIND_EOF     = 4'd9
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [OFFSET_BITS-1:0] start_off;
        logic [OFFSET_BITS-1:0] end_off;
        logic                   last;
    } t_token;

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {[8'h30:8'h39]});
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]}) || is_digit(c) ||
               (c == CH_UNDER) || (c == CH_DOT) || (c == CH_SLASH) || (c == CH_DASH);
    endfunction

endpackage

// ===== design/script_text_tokenizer.sv =====
// Script text tokenizer: byte stream in, token records out.
// Depends on stt_pkg for token codes, scan modes and character classes.
//
// Usage
//   Slave stream s_axis: one text byte per item in s_axis_tdata, with
//   s_axis_tuser[0] set on the end-of-text item (its data byte is ignored).
//   Master stream m_axis: one token per item; tdata carries the start offset
//   (low word) and the end offset (high word, one past the last byte), tuser
//   the token kind, tlast the final token caused by one input item.
//   Latency: tokens an input item causes are written to the output queue at
//   the edge that accepts it and are offered on m_axis after older queued tokens.
//   Throughput: one input item per cycle while s_axis_tready is high. The scan
//   state update and the token build are one short compare-and-select pass;
//   an item that closes a run and also yields a single-byte token, or ends
//   the text with a token pending, gives two results, and the four-entry
//   output queue absorbs these, holding the input off when it fills, while
//   m_axis drains one token per cycle whenever m_axis_tready is high.
//   Stall: s_axis_tready drops when the queue has fewer than two free
//   entries; tokens are never dropped and hold while m_axis_tready is low.
//   Reset (synchronous, active low): clear the scan mode, offsets and queue.
//   End of text flushes the pending token, emits the eof token and returns
//   the scanner to its reset state.
module script_text_tokenizer
    import stt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,  // [7:0] byte_value
    input  logic [0:0]            s_axis_tuser,  // [0] action (1 = end of text)
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [TDATA_BITS-1:0] m_axis_tdata,  // [31:0] start_offset, [63:32] end_offset
    output logic [3:0]            m_axis_tuser,  // [3:0] token_kind
    output logic                  m_axis_tlast   // last result of this input item
);

    // scanner state
    t_mode                  r_mode, n_mode;
    logic                   r_sq, n_sq;          // string opened by a single quote
    logic [OFFSET_BITS-1:0] r_ts, n_ts;          // start of the pending token
    logic [OFFSET_BITS-1:0] r_pos, n_pos;        // offset of the next byte

    // output queue
    t_token               r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [FIFO_CW-1:0]   r_count, n_count;

    logic                   in_acc, out_pop, eot, do_scan;
    logic [7:0]             c;
    logic [OFFSET_BITS-1:0] pos_nxt;
    logic                   close_vld, scan_vld;
    t_token                 close_tok, scan_tok, slot0, slot1;
    logic [1:0]             emit_cnt;

    assign s_axis_tready = (r_count <= FIFO_CW'(FIFO_DEPTH - 2));
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_pop       = m_axis_tvalid && m_axis_tready;
    assign eot           = s_axis_tuser[0];
    assign c             = s_axis_tdata;
    assign pos_nxt       = r_pos + OFFSET_BITS'(1);

    // Scan one item: eot flushes; else close a run, scan when idle or after number/ident.
    always_comb begin
        n_mode    = r_mode;
        n_sq      = r_sq;
        n_ts      = r_ts;
        n_pos     = r_pos;
        close_vld = 1'b0;
        scan_vld  = 1'b0;
        do_scan   = 1'b0;
        close_tok = '{kind: KIND_COMMENT, start_off: r_ts, end_off: r_pos, last: 1'b0};
        scan_tok  = '{kind: KIND_UNKNOWN, start_off: r_pos, end_off: pos_nxt, last: 1'b1};

        if (in_acc) begin
            if (eot) begin
                // flush any pending run, then the eof marker; back to reset state
                close_vld = (r_mode != MODE_IDLE);
                case (r_mode)
                    MODE_COMMENT: close_tok.kind = KIND_COMMENT;
                    MODE_STRING:  close_tok.kind = KIND_STRING;
                    MODE_NUMBER:  close_tok.kind = KIND_NUMBER;
                    MODE_IDENT:   close_tok.kind = KIND_IDENT;
                    default:      close_tok.kind = KIND_COMMENT;
                endcase
                scan_vld          = 1'b1;
                scan_tok.kind     = KIND_EOF;
                scan_tok.end_off  = r_pos;
                n_mode            = MODE_IDLE;
                n_sq              = 1'b0;
                n_ts              = '0;
                n_pos             = '0;
            end else begin
                n_pos = pos_nxt;
                case (r_mode)
                    MODE_COMMENT: begin
                        if (c == CH_NL) begin
                            close_vld = 1'b1;
                            n_mode    = MODE_IDLE;
                        end
                    end
                    MODE_STRING: begin
                        if (c == (r_sq ? CH_SQUOTE : CH_DQUOTE)) begin
                            close_vld         = 1'b1;
                            close_tok.kind    = KIND_STRING;
                            close_tok.end_off = pos_nxt;
                            n_mode            = MODE_IDLE;
                            n_sq              = 1'b0;
                        end
                    end
                    MODE_NUMBER: begin
                        if (!is_digit(c)) begin
                            close_vld      = 1'b1;
                            close_tok.kind = KIND_NUMBER;
                            n_mode         = MODE_IDLE;
                            do_scan        = 1'b1;
                        end
                    end
                    MODE_IDENT: begin
                        if (!is_ident(c)) begin
                            close_vld      = 1'b1;
                            close_tok.kind = KIND_IDENT;
                            n_mode         = MODE_IDLE;
                            do_scan        = 1'b1;
                        end
                    end
                    default: begin
                        n_mode  = MODE_IDLE;
                        do_scan = 1'b1;
                    end
                endcase

                // fresh scan of the byte with nothing pending
                if (do_scan && !is_space(c)) begin
                    if (c == CH_HASH) begin
                        n_mode = MODE_COMMENT;
                        n_ts   = r_pos;
                    end else if (c == CH_EQUALS) begin
                        scan_vld      = 1'b1;
                        scan_tok.kind = KIND_EQUALS;
                    end else if (c == CH_COLON) begin
                        scan_vld      = 1'b1;
                        scan_tok.kind = KIND_COLON;
                    end else if (c == CH_LBRACE) begin
                        scan_vld      = 1'b1;
                        scan_tok.kind = KIND_OPEN;
                    end else if (c == CH_RBRACE) begin
                        scan_vld      = 1'b1;
                        scan_tok.kind = KIND_CLOSE;
                    end else if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
                        n_mode = MODE_STRING;
                        n_sq   = (c == CH_SQUOTE);
                        n_ts   = r_pos;
                    end else if (is_digit(c)) begin
                        n_mode = MODE_NUMBER;
                        n_ts   = r_pos;
                    end else if (is_ident(c)) begin
                        n_mode = MODE_IDENT;
                        n_ts   = r_pos;
                    end else begin
                        scan_vld = 1'b1;
                    end
                end
            end
        end
    end

    // Pack the results of this item into consecutive queue slots; mark the final one.
    always_comb begin
        slot0      = close_vld ? close_tok : scan_tok;
        slot0.last = !(close_vld && scan_vld);
        slot1      = scan_tok;
        emit_cnt   = {1'b0, close_vld} + {1'b0, scan_vld};
        n_count    = r_count + FIFO_CW'(emit_cnt) - FIFO_CW'(out_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_sq     <= 1'b0;
            r_ts     <= '0;
            r_pos    <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_mode   <= n_mode;
            r_sq     <= n_sq;
            r_ts     <= n_ts;
            r_pos    <= n_pos;
            r_count  <= n_count;
            r_wr_ptr <= r_wr_ptr + FIFO_AW'(emit_cnt);
            if (out_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
        end
    end

    // queue payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (emit_cnt != 2'd0) begin
            r_fifo[r_wr_ptr] <= slot0;
        end
        if (emit_cnt == 2'd2) begin
            r_fifo[r_wr_ptr + FIFO_AW'(1)] <= slot1;
        end
    end

    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = {r_fifo[r_rd_ptr].end_off, r_fifo[r_rd_ptr].start_off};
    assign m_axis_tuser  = r_fifo[r_rd_ptr].kind;
    assign m_axis_tlast  = r_fifo[r_rd_ptr].last;

    // queue never overflows
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("token queue overflow");

    // a text byte advances the position by one
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !eot) |=> (r_pos == $past(r_pos) + OFFSET_BITS'(1)))
        else $error("byte position did not advance");

    // end of text returns the scanner to its reset state
    a_eot_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && eot) |=> (r_mode == MODE_IDLE && r_pos == '0 && !r_sq))
        else $error("scanner not reset after end of text");

    // end of text always leaves at least the eof token queued
    a_eof_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && eot) |=> m_axis_tvalid)
        else $error("no token queued after end of text");

endmodule
